>>> hdl/epf_pkg.sv
// Shared types and constants of the e-paper line formatter.
package epf_pkg;

    localparam int DATA_DEPTH_DEF     = 32;
    localparam int LINE_BYTES_MAX_DEF = 128;

    localparam int LEN_W  = 8;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 6;

    localparam logic [CFG_IW-1:0] REG_DATA_BYTES  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SCAN_BYTES  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_MIDDLE_SCAN = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LEAD_BORDER = 3'd3;
    localparam logic [CFG_IW-1:0] REG_TRAIL_MODE  = 3'd4;

    localparam logic [5:0] DATA_BYTES_RST = 6'd25;
    localparam logic [5:0] SCAN_BYTES_RST = 6'd24;
    localparam logic       MIDDLE_RST     = 1'b1;
    localparam logic       LEAD_RST       = 1'b1;
    localparam logic [1:0] TRAIL_RST      = 2'd0;

    localparam logic [1:0] TB_NONE  = 2'd0;
    localparam logic [1:0] TB_ZERO  = 2'd1;
    localparam logic [1:0] TB_STAGE = 2'd2;
    // spare mode, adds no trailing byte
    localparam logic [1:0] TB_RSVD  = 2'd3;

    localparam logic [1:0] STG_COMP   = 2'd0;
    localparam logic [1:0] STG_WHITE  = 2'd1;
    localparam logic [1:0] STG_INV    = 2'd2;
    localparam logic [1:0] STG_NORMAL = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EMIT = 1'b1;

    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    localparam logic [7:0]  K_AA   = 8'haa;
    localparam logic [7:0]  K_55   = 8'h55;
    localparam logic [15:0] K_AAAA = 16'haaaa;
    localparam logic [15:0] K_5555 = 16'h5555;
    localparam logic [7:0]  K_C0   = 8'hc0;
    localparam logic [7:0]  K_06   = 8'h06;
    localparam logic [7:0]  K_03   = 8'h03;

    typedef enum logic [2:0] {
        BK_LIT,
        BK_ODD,
        BK_EVEN,
        BK_PAIR_HI,
        BK_PAIR_LO
    } byte_kind_t;

    // one line byte handed from the sequencer to the datapath
    typedef struct packed {
        logic       valid;
        byte_kind_t kind;
        logic [7:0] lit;
        logic [1:0] stage;
        logic       masked;
        logic       last;
        logic       cut;
    } byte_cmd_t;

    typedef struct packed {
        logic       en;
        logic [7:0] image;
        logic [7:0] mask;
    } store_wr_t;

    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] fill_byte;
        logic       use_mask;
        logic       use_image;
        logic [1:0] stage;
        logic [7:0] line_index;
        logic [7:0] mask_byte;
        logic [7:0] image_byte;
        logic [4:0] byte_index;
    } in_data_t;

    typedef struct packed {
        logic [5:0] pad;
        logic [1:0] byte_count;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
    } out_data_t;

endpackage

>>> hdl/epf_ctrl.sv
// Sequencer of the e-paper line formatter: config registers and line segment walk.
module epf_ctrl #(
    parameter int DATA_DEPTH     = epf_pkg::DATA_DEPTH_DEF,
    parameter int LINE_BYTES_MAX = epf_pkg::LINE_BYTES_MAX_DEF,
    parameter int AW             = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,
    input  logic                        s_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [epf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [epf_pkg::CFG_DW-1:0]  cfg_data,
    output epf_pkg::byte_cmd_t          cmd,
    output logic [AW-1:0]               cmd_addr,
    input  logic                        cmd_ready,
    output epf_pkg::store_wr_t          wr,
    output logic [AW-1:0]               wr_addr
);
    import epf_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    typedef enum logic [2:0] {
        SEG_LEAD, SEG_ODD, SEG_SCAN_M, SEG_EVEN,
        SEG_SCAN_O, SEG_PAIR, SEG_SCAN_E, SEG_TRAIL
    } seg_t;

    state_t           state_reg, state_next;
    seg_t             seg_reg, seg_next;
    logic [LEN_W-1:0] seg_left_reg, seg_left_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             cut_reg, cut_next;
    logic [7:0]       line_reg, line_next;
    logic [1:0]       stage_reg, stage_next;
    logic             img_reg, img_next;
    logic             msk_reg, msk_next;
    logic [7:0]       fixed_reg, fixed_next;
    logic [5:0]       data_bytes_reg, data_bytes_next;
    logic [5:0]       scan_bytes_reg, scan_bytes_next;
    logic             middle_reg, middle_next;
    logic             lead_reg, lead_next;
    logic [1:0]       trail_reg, trail_next;

    in_data_t         din;
    logic             in_fire;
    logic [6:0]       nd;
    logic             trail_on;
    logic [8:0]       n_total;
    logic             cut_now;
    logic [LEN_W-1:0] len_now;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] down_b;
    logic [LEN_W-1:0] up_b;
    logic [LEN_W-1:0] pair_b;
    logic [LEN_W-1:0] idx_b;
    logic             issue;

    function automatic seg_t seg_after(seg_t s, logic middle);
        seg_t r;
        case (s)
            SEG_LEAD:   r = middle ? SEG_ODD : SEG_SCAN_O;
            SEG_ODD:    r = SEG_SCAN_M;
            SEG_SCAN_M: r = SEG_EVEN;
            SEG_EVEN:   r = SEG_TRAIL;
            SEG_SCAN_O: r = SEG_PAIR;
            SEG_PAIR:   r = SEG_SCAN_E;
            SEG_SCAN_E: r = SEG_TRAIL;
            default:    r = SEG_TRAIL;
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] seg_length(seg_t s, logic [6:0] n_data,
                                                    logic [5:0] n_scan, logic lead,
                                                    logic trail);
        logic [LEN_W-1:0] r;
        case (s)
            SEG_LEAD:                      r = LEN_W'(lead);
            SEG_ODD, SEG_EVEN:             r = LEN_W'(n_data);
            SEG_SCAN_M, SEG_SCAN_O,
            SEG_SCAN_E:                    r = LEN_W'(n_scan);
            SEG_PAIR:                      r = LEN_W'({n_data, 1'b0});
            SEG_TRAIL:                     r = LEN_W'(trail);
            default:                       r = '0;
        endcase
        return r;
    endfunction

    assign din       = in_data_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;

    // store write for a load transaction; positions beyond the store are dropped
    assign wr.en    = in_fire && (s_tuser == REQ_LOAD) &&
                      ({2'b00, din.byte_index} < 7'(DATA_DEPTH));
    assign wr.image = din.image_byte;
    assign wr.mask  = din.mask_byte;
    assign wr_addr  = AW'(din.byte_index);

    always_comb begin
        nd = ({1'b0, data_bytes_reg} > 7'(DATA_DEPTH)) ? 7'(DATA_DEPTH)
                                                        : {1'b0, data_bytes_reg};
        trail_on = (trail_reg == TB_ZERO) || (trail_reg == TB_STAGE);
        n_total  = 9'(lead_reg) + 9'(trail_on) + 9'({nd, 1'b0}) +
                   (middle_reg ? 9'(scan_bytes_reg) : 9'({scan_bytes_reg, 1'b0}));
        cut_now  = n_total > 9'(LINE_BYTES_MAX);
        len_now  = cut_now ? LEN_W'(LINE_BYTES_MAX) : n_total[LEN_W-1:0];
    end

    always_comb begin
        cur_len = seg_length(seg_reg, nd, scan_bytes_reg, lead_reg, trail_on);
        down_b  = seg_left_reg - LEN_W'(1);
        up_b    = cur_len - seg_left_reg;
        pair_b  = {1'b0, down_b[LEN_W-1:1]};
        issue   = (state_reg == ST_RUN) && (seg_left_reg != '0);

        cmd.valid  = issue;
        cmd.stage  = stage_reg;
        cmd.masked = msk_reg;
        cmd.last   = (rem_reg == LEN_W'(1));
        cmd.cut    = cut_reg;
        cmd.kind   = BK_LIT;
        cmd.lit    = '0;
        idx_b      = down_b;
        case (seg_reg)
            SEG_ODD: begin
                cmd.kind = img_reg ? BK_ODD : BK_LIT;
                cmd.lit  = fixed_reg;
            end
            SEG_EVEN: begin
                cmd.kind = img_reg ? BK_EVEN : BK_LIT;
                cmd.lit  = fixed_reg;
                idx_b    = up_b;
            end
            SEG_PAIR: begin
                // high byte first: seg_left is even on the high half
                if (img_reg) begin
                    cmd.kind = seg_left_reg[0] ? BK_PAIR_LO : BK_PAIR_HI;
                end
                cmd.lit = fixed_reg;
                idx_b   = pair_b;
            end
            SEG_SCAN_M: begin
                if ({2'b00, line_reg[7:2]} == down_b) begin
                    cmd.lit = K_03 << {line_reg[1:0], 1'b0};
                end
            end
            SEG_SCAN_O: begin
                if (line_reg[0] && ({3'b000, line_reg[7:3]} == up_b)) begin
                    cmd.lit = K_C0 >> (line_reg & K_06);
                end
            end
            SEG_SCAN_E: begin
                if (!line_reg[0] && ({3'b000, line_reg[7:3]} == down_b)) begin
                    cmd.lit = K_03 << (line_reg & K_06);
                end
            end
            SEG_TRAIL: begin
                if ((trail_reg == TB_STAGE) && (stage_reg == STG_NORMAL)) begin
                    cmd.lit = K_AA;
                end
            end
            default: begin
                cmd.lit = '0;
            end
        endcase
        cmd_addr = idx_b[AW-1:0];
    end

    always_comb begin
        state_next      = state_reg;
        seg_next        = seg_reg;
        seg_left_next   = seg_left_reg;
        rem_next        = rem_reg;
        cut_next        = cut_reg;
        line_next       = line_reg;
        stage_next      = stage_reg;
        img_next        = img_reg;
        msk_next        = msk_reg;
        fixed_next      = fixed_reg;
        data_bytes_next = data_bytes_reg;
        scan_bytes_next = scan_bytes_reg;
        middle_next     = middle_reg;
        lead_next       = lead_reg;
        trail_next      = trail_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_DATA_BYTES:  data_bytes_next = cfg_data;
                REG_SCAN_BYTES:  scan_bytes_next = cfg_data;
                REG_MIDDLE_SCAN: middle_next     = cfg_data[0];
                REG_LEAD_BORDER: lead_next       = cfg_data[0];
                REG_TRAIL_MODE:  trail_next      = cfg_data[1:0];
                default:         trail_next      = trail_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser == REQ_EMIT) && (len_now != '0)) begin
                    state_next    = ST_RUN;
                    seg_next      = SEG_LEAD;
                    seg_left_next = LEN_W'(lead_reg);
                    rem_next      = len_now;
                    cut_next      = cut_now;
                    line_next     = din.line_index;
                    stage_next    = din.stage;
                    img_next      = din.use_image;
                    msk_next      = din.use_image && din.use_mask;
                    fixed_next    = din.fill_byte;
                end
            end
            ST_RUN: begin
                if (seg_left_reg == '0) begin
                    // step to the next segment; an empty segment is stepped through like any other
                    seg_next      = seg_after(seg_reg, middle_reg);
                    seg_left_next = seg_length(seg_after(seg_reg, middle_reg), nd,
                                               scan_bytes_reg, lead_reg, trail_on);
                end else if (cmd_ready) begin
                    seg_left_next = seg_left_reg - LEN_W'(1);
                    rem_next      = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seg_reg        <= SEG_LEAD;
            seg_left_reg   <= '0;
            rem_reg        <= '0;
            data_bytes_reg <= DATA_BYTES_RST;
            scan_bytes_reg <= SCAN_BYTES_RST;
            middle_reg     <= MIDDLE_RST;
            lead_reg       <= LEAD_RST;
            trail_reg      <= TRAIL_RST;
        end else begin
            state_reg      <= state_next;
            seg_reg        <= seg_next;
            seg_left_reg   <= seg_left_next;
            rem_reg        <= rem_next;
            data_bytes_reg <= data_bytes_next;
            scan_bytes_reg <= scan_bytes_next;
            middle_reg     <= middle_next;
            lead_reg       <= lead_next;
            trail_reg      <= trail_next;
        end
        cut_reg   <= cut_next;
        line_reg  <= line_next;
        stage_reg <= stage_next;
        img_reg   <= img_next;
        msk_reg   <= msk_next;
        fixed_reg <= fixed_next;
    end

`ifndef SYNTH
    a_run_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (rem_reg != '0))
        else $error("sequencer running with no bytes left");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.valid && cmd.last && cmd_ready) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not stop after the last byte");
`endif

endmodule

>>> hdl/epf_datapath.sv
// Datapath of the e-paper line formatter: line store, pixel coding, pair packing, output.
module epf_datapath #(
    parameter int DATA_DEPTH = epf_pkg::DATA_DEPTH_DEF,
    parameter int AW         = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  epf_pkg::byte_cmd_t cmd,
    input  logic [AW-1:0]      cmd_addr,
    output logic               cmd_ready,
    input  epf_pkg::store_wr_t wr,
    input  logic [AW-1:0]      wr_addr,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);
    import epf_pkg::*;

    logic [7:0] image_mem [DATA_DEPTH];
    logic [7:0] mask_mem  [DATA_DEPTH];

    byte_cmd_t  s1_cmd_reg;
    logic [7:0] rd_img_reg;
    logic [7:0] rd_msk_reg;

    logic       half_valid_reg, half_valid_next;
    logic [7:0] half_byte_reg, half_byte_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_first_reg, out_first_next;
    logic [7:0] out_second_reg, out_second_next;
    logic [1:0] out_count_reg, out_count_next;
    logic       out_last_reg, out_last_next;
    logic       out_trunc_reg, out_trunc_next;

    logic [15:0] pair_w;
    logic [7:0]  line_byte;
    logic        out_free;
    logic        s1_take;
    out_data_t   dout;

    function automatic logic [15:0] spread(logic [7:0] v);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[2*i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] odd_code(logic [7:0] img, logic [7:0] old,
                                            logic [1:0] stage, logic masked);
        logic [7:0] px;
        logic [7:0] pm;
        logic [7:0] pd;
        px = img & K_55;
        pm = 8'hff;
        if (masked) begin
            pm = (old ^ px) & K_55;
            pm = pm | (pm << 1);
        end
        case (stage)
            STG_COMP:  pd = K_AA | (px ^ K_55);
            STG_WHITE: pd = K_55 + (px ^ K_55);
            STG_INV:   pd = K_55 | ((px ^ K_55) << 1);
            default:   pd = K_AA | px;
        endcase
        return (pd & pm) | (~pm & K_55);
    endfunction

    function automatic logic [7:0] even_code(logic [7:0] img, logic [7:0] old,
                                             logic [1:0] stage, logic masked);
        logic [7:0] px;
        logic [7:0] pm;
        logic [7:0] pd;
        logic [7:0] pc;
        px = img & K_AA;
        pm = 8'hff;
        if (masked) begin
            pm = (old ^ px) & K_AA;
            pm = pm | (pm >> 1);
        end
        case (stage)
            STG_COMP:  pd = K_AA | ((px ^ K_AA) >> 1);
            STG_WHITE: pd = K_55 + ((px ^ K_AA) >> 1);
            STG_INV:   pd = K_55 | (px ^ K_AA);
            default:   pd = K_AA | (px >> 1);
        endcase
        pc = (pd & pm) | (~pm & K_55);
        // reverse the order of the bit pairs
        return {pc[1:0], pc[3:2], pc[5:4], pc[7:6]};
    endfunction

    function automatic logic [15:0] pair_code(logic [7:0] img, logic [7:0] old,
                                              logic [1:0] stage, logic masked);
        logic [15:0] px;
        logic [15:0] pm;
        logic [15:0] pd;
        px = spread(img);
        pm = 16'hffff;
        if (masked) begin
            pm = (spread(old) ^ px) & K_5555;
            pm = pm | (pm << 1);
        end
        case (stage)
            STG_COMP:  pd = K_AAAA | (px ^ K_5555);
            STG_WHITE: pd = K_5555 + (px ^ K_5555);
            STG_INV:   pd = K_5555 | ((px ^ K_5555) << 1);
            default:   pd = K_AAAA | px;
        endcase
        return (pd & pm) | (~pm & K_5555);
    endfunction

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            image_mem[wr_addr] <= wr.image;
            mask_mem[wr_addr]  <= wr.mask;
        end
    end

    // stage one: registered store read alongside the byte command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_cmd_reg <= '0;
        end else if (cmd_ready) begin
            s1_cmd_reg <= cmd;
        end
        if (cmd_ready && cmd.valid) begin
            rd_img_reg <= image_mem[cmd_addr];
            rd_msk_reg <= mask_mem[cmd_addr];
        end
    end

    always_comb begin
        pair_w = pair_code(rd_img_reg, rd_msk_reg, s1_cmd_reg.stage, s1_cmd_reg.masked);
        case (s1_cmd_reg.kind)
            BK_ODD:     line_byte = odd_code(rd_img_reg, rd_msk_reg, s1_cmd_reg.stage,
                                             s1_cmd_reg.masked);
            BK_EVEN:    line_byte = even_code(rd_img_reg, rd_msk_reg, s1_cmd_reg.stage,
                                              s1_cmd_reg.masked);
            BK_PAIR_HI: line_byte = pair_w[15:8];
            BK_PAIR_LO: line_byte = pair_w[7:0];
            default:    line_byte = s1_cmd_reg.lit;
        endcase
    end

    always_comb begin
        out_free        = !out_valid_reg || m_tready;
        half_valid_next = half_valid_reg;
        half_byte_next  = half_byte_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;
        s1_take         = 1'b0;

        if (s1_cmd_reg.valid) begin
            if (!half_valid_reg && !s1_cmd_reg.last) begin
                // hold the earlier byte of the pair
                s1_take         = 1'b1;
                half_valid_next = 1'b1;
                half_byte_next  = line_byte;
            end else if (out_free) begin
                s1_take         = 1'b1;
                half_valid_next = 1'b0;
                out_valid_next  = 1'b1;
                out_last_next   = s1_cmd_reg.last;
                out_trunc_next  = s1_cmd_reg.last && s1_cmd_reg.cut;
                if (half_valid_reg) begin
                    out_first_next  = half_byte_reg;
                    out_second_next = line_byte;
                    out_count_next  = CNT_TWO;
                end else begin
                    out_first_next  = line_byte;
                    out_second_next = '0;
                    out_count_next  = CNT_ONE;
                end
            end
        end
        cmd_ready = !s1_cmd_reg.valid || s1_take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            half_valid_reg <= half_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        half_byte_reg  <= half_byte_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
        out_trunc_reg  <= out_trunc_next;
    end

    always_comb begin
        dout.pad         = '0;
        dout.byte_count  = out_count_reg;
        dout.second_byte = out_second_reg;
        dout.first_byte  = out_first_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dout;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

`ifndef SYNTH
    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_trunc_reg) |-> out_last_reg)
        else $error("truncated flag away from the end of a line");

    a_single_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_count_reg == CNT_ONE)) |-> out_last_reg)
        else $error("single byte transaction before the end of a line");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_cmd_reg.valid && !cmd_ready) |=> s1_cmd_reg.valid)
        else $error("stalled line byte dropped");
`endif

endmodule

>>> hdl/epaper_line_formatter.sv
// Top level of the e-paper line formatter.
//
// Usage: s_ carries request transactions, s_tuser = 0 loads one image byte and
// one mask byte into the line store, s_tuser = 1 emits a formatted panel line.
// m_ carries the line as byte pair transactions; m_tlast marks the final pair,
// m_tuser flags that the line was cut at LINE_BYTES_MAX bytes.
// cfg_ writes the layout registers by index; write only while no line is in flight.
// Throughput: loads and emits are taken only while the sequencer is idle. After
// an emit the sequencer walks the line one byte per cycle while the datapath
// takes them, and issues no byte on a step to the next segment, empty ones included.
// The first pair passes the store read register, the pairing register and the
// output register before it is presented; segment steps before its second byte
// delay it.
// While a line of n bytes is emitted, the request side is busy for the accept,
// the n bytes and up to four segment steps, and longer when the receiver stalls.
// The next request is taken as soon as the last byte is issued, while the
// final pairs are still draining.
// A stall on m_tready holds the output register and backs up the pipeline to
// the sequencer; nothing is dropped. Reset restores the register defaults and
// empties the pipeline; the line store is not cleared.
module epaper_line_formatter #(
    parameter int DATA_DEPTH     = epf_pkg::DATA_DEPTH_DEF,
    parameter int LINE_BYTES_MAX = epf_pkg::LINE_BYTES_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // byte_index[4:0] image_byte[12:5] mask_byte[20:13] line_index[28:21]
    // stage[30:29] use_image[31] use_mask[32] fill_byte[40:33], zero above
    input  logic [47:0]                s_tdata,
    // req_type[0]
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // first_byte[7:0] second_byte[15:8] byte_count[17:16], zero above
    output logic [23:0]                m_tdata,
    output logic                       m_tlast,
    // truncated[0]
    output logic                       m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [epf_pkg::CFG_IW-1:0] cfg_index,
    input  logic [epf_pkg::CFG_DW-1:0] cfg_data
);
    import epf_pkg::*;

    localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    byte_cmd_t     cmd;
    logic [AW-1:0] cmd_addr;
    logic          cmd_ready;
    store_wr_t     wr;
    logic [AW-1:0] wr_addr;

    epf_ctrl #(
        .DATA_DEPTH     (DATA_DEPTH),
        .LINE_BYTES_MAX (LINE_BYTES_MAX),
        .AW             (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_addr  (cmd_addr),
        .cmd_ready (cmd_ready),
        .wr        (wr),
        .wr_addr   (wr_addr)
    );

    epf_datapath #(
        .DATA_DEPTH (DATA_DEPTH),
        .AW         (AW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_addr  (cmd_addr),
        .cmd_ready (cmd_ready),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
